[rtl/core/hlm_pkg.sv]
// Shared types, request codes and reset constants for the heartbeat link monitor.
`default_nettype none
package hlm_pkg;

	localparam logic [1:0] REQ_TICK      = 2'd0;
	localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
	localparam logic [1:0] REQ_CHECK     = 2'd2;

	localparam logic [31:0] WAIT_FLAG   = 32'h8000_0000;
	localparam logic [31:0] TIMEOUT_RST = 32'd2000;

	typedef struct packed {
		logic accept;
		logic scan;
		logic out_load;
		logic cfg_we;
	} cmd_t;

	typedef struct packed {
		logic is_check;
		logic scan_end;
	} sts_t;

	function automatic logic [31:0] init_mask(int n, int none_u, int sys_u);
		logic [31:0] m;
		m = WAIT_FLAG;
		for (int i = 0; i < 31; i++) begin
			if (i < n && i != none_u && i != sys_u) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/core/hlm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hlm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/hlm_ctrl.sv]
// Controller state machine: accepts items, sequences the check scan, loads results.
`default_nettype none
module hlm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire hlm_pkg::sts_t sts,
	output hlm_pkg::cmd_t      cmd
);
	import hlm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   idle;

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		cmd.accept   = idle && in_valid;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		cmd.cfg_we   = idle && cfg_valid;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.is_check ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (cmd.out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = !idle;
	assign cfg_ready = idle;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[rtl/core/hlm_dp.sv]
// Datapath: time counter, timestamps, heard flags, status mask, scan unit, result registers.
`default_nettype none
module hlm_dp #(
	parameter int NUM_UNITS   = 16,
	parameter int NONE_UNIT   = 0,
	parameter int SYSTEM_UNIT = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hlm_pkg::cmd_t cmd,
	output hlm_pkg::sts_t      sts,
	input  wire logic [1:0]    req_type,
	input  wire logic [4:0]    unit_index,
	input  wire logic [31:0]   cfg_data,
	output logic               check_ok,
	output logic               all_linked,
	output logic [31:0]        status_mask,
	output logic               index_error
);
	import hlm_pkg::*;

	localparam int UW = $clog2(NUM_UNITS);
	localparam int CW = $clog2(NUM_UNITS + 1);
	localparam logic [31:0] MASK_RST = init_mask(NUM_UNITS, NONE_UNIT, SYSTEM_UNIT);

	logic [31:0]          time_q;
	logic [31:0]          timeout_q;
	logic [31:0]          status_q;
	logic [NUM_UNITS-1:0] heard_q;
	logic                 ok_q;
	logic                 ierr_q;
	logic [CW-1:0]        cnt_q;
	logic                 vld_s1;
	logic [UW-1:0]        idx_s1;

	logic                 idx_in_range;
	logic                 hb_we;
	logic [31:0]          seen_rdata;
	logic [31:0]          age;
	logic                 hit;
	logic [31:0]          hb_mask;

	assign idx_in_range = (unit_index < 5'(NUM_UNITS));
	assign hb_we        = cmd.accept && (req_type == REQ_HEARTBEAT) && idx_in_range;
	assign hb_mask      = status_q & ~(32'd1 << unit_index);

	hlm_ram #(
		.WIDTH(32),
		.DEPTH(NUM_UNITS)
	) u_seen_ram (
		.clk  (clk),
		.we   (hb_we),
		.waddr(unit_index[UW-1:0]),
		.wdata(time_q),
		.raddr(cnt_q[UW-1:0]),
		.rdata(seen_rdata)
	);

	assign age = time_q - seen_rdata;
	assign hit = vld_s1 && heard_q[idx_s1] && (age > timeout_q);

	assign sts.is_check = (req_type == REQ_CHECK);
	assign sts.scan_end = hit || (vld_s1 && idx_s1 == UW'(NUM_UNITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			timeout_q <= TIMEOUT_RST;
			status_q  <= MASK_RST;
			heard_q   <= '0;
			vld_s1    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cmd.cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (cmd.accept) begin
				cnt_q <= CW'(1);
				case (req_type)
					REQ_TICK: time_q <= time_q + 32'd1;
					REQ_HEARTBEAT: begin
						if (idx_in_range) begin
							heard_q[unit_index[UW-1:0]] <= 1'b1;
							status_q <= (hb_mask == WAIT_FLAG) ? 32'd0 : hb_mask;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan) begin
				if (cnt_q < CW'(NUM_UNITS)) begin
					cnt_q  <= cnt_q + CW'(1);
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (hit) begin
					status_q <= status_q | (32'd1 << idx_s1);
				end
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			idx_s1 <= cnt_q[UW-1:0];
		end
		if (cmd.accept) begin
			ok_q   <= 1'b1;
			ierr_q <= (req_type == REQ_HEARTBEAT) && !idx_in_range;
		end else if (cmd.scan && hit) begin
			ok_q <= 1'b0;
		end
		if (cmd.out_load) begin
			check_ok    <= ok_q;
			all_linked  <= (status_q == 32'd0);
			status_mask <= status_q;
			index_error <= ierr_q;
		end
	end

endmodule
`default_nettype wire

[rtl/core/heartbeat_link_monitor.sv]
// Heartbeat link monitor top level: controller plus datapath.
// Tick and heartbeat: the controller passes from idle to done, loads the result register once
// the output register is free, then returns to idle for the next item. Check: one stored
// timestamp read per cycle; the scan ends at the last unit or early on a timeout.
// A new item is taken while the previous result is still waiting at the output register.
// arst_n clears time and heard flags, sets timeout to 2000; status mask resets to the waiting
// flag plus every unit other than the none and system units. Timestamps are not cleared.
`default_nettype none
module heartbeat_link_monitor #(
	parameter int NUM_UNITS   = 16,
	parameter int NONE_UNIT   = 0,
	parameter int SYSTEM_UNIT = 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [4:0]  unit_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             check_ok,
	output logic             all_linked,
	output logic [31:0]      status_mask,
	output logic             index_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import hlm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hlm_dp #(
		.NUM_UNITS  (NUM_UNITS),
		.NONE_UNIT  (NONE_UNIT),
		.SYSTEM_UNIT(SYSTEM_UNIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.unit_index (unit_index),
		.cfg_data   (cfg_data),
		.check_ok   (check_ok),
		.all_linked (all_linked),
		.status_mask(status_mask),
		.index_error(index_error)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input transfer did not make the block busy");

	a_linked_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (all_linked == (status_mask == 32'd0)))
		else $error("all_linked disagrees with status_mask");

	a_fail_no_index_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !check_ok) |-> !index_error)
		else $error("check failure reported together with index error");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.out_load)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for heartbeat_link_monitor with a predictor and random handshakes.
module testbench;
	import hlm_pkg::*;

	localparam int NUM_UNITS       = 16;
	localparam int NONE_UNIT       = 0;
	localparam int SYSTEM_UNIT     = 1;
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam int SETTLE_CYCLES   = NUM_UNITS + 8;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASE_ITEMS     = 165;

	typedef struct packed {
		logic [1:0] req;
		logic [4:0] unit;
	} hb_item_t;

	typedef struct packed {
		logic        ok;
		logic        linked;
		logic [31:0] mask;
		logic        ierr;
	} hb_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_TICK;
	logic [4:0]  unit_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        check_ok;
	logic        all_linked;
	logic [31:0] status_mask;
	logic        index_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	heartbeat_link_monitor #(
		.NUM_UNITS  (NUM_UNITS),
		.NONE_UNIT  (NONE_UNIT),
		.SYSTEM_UNIT(SYSTEM_UNIT)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.unit_index (unit_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.check_ok   (check_ok),
		.all_linked (all_linked),
		.status_mask(status_mask),
		.index_error(index_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted block state
	logic [31:0]          clock_ticks;
	logic [31:0]          stamp [NUM_UNITS];
	logic [NUM_UNITS-1:0] heard_units;
	logic [31:0]          unit_status;
	logic [31:0]          timeout_limit;

	hb_item_t   pending_items[$];
	hb_result_t expected_status[$];
	int         errors = 0;
	int         idle_cycles = 0;
	bit         in_taken = 0;
	bit         out_taken = 0;
	bit         in_burst = 0;
	bit         out_burst = 0;
	int         in_gap = 0;
	int         stall_left = 0;

	function automatic void reset_model();
		clock_ticks   = '0;
		heard_units   = '0;
		timeout_limit = TIMEOUT_RST;
		unit_status   = WAIT_FLAG;
		for (int u = 0; u < NUM_UNITS; u++) begin
			stamp[u] = '0;
			if (u != NONE_UNIT && u != SYSTEM_UNIT) begin
				unit_status[u] = 1'b1;
			end
		end
	endfunction

	function automatic hb_result_t predict_status(hb_item_t it);
		hb_result_t r;
		logic [31:0] age;
		bit found;
		r.ok   = 1'b1;
		r.ierr = 1'b0;
		found  = 0;
		case (it.req)
			REQ_TICK: begin
				clock_ticks = clock_ticks + 32'd1;
			end
			REQ_HEARTBEAT: begin
				if (it.unit < NUM_UNITS) begin
					stamp[it.unit]       = clock_ticks;
					heard_units[it.unit] = 1'b1;
					unit_status[it.unit] = 1'b0;
					if (unit_status == WAIT_FLAG) begin
						unit_status = '0;
					end
				end else begin
					r.ierr = 1'b1;
				end
			end
			REQ_CHECK: begin
				for (int u = 1; u < NUM_UNITS; u++) begin
					if (!found && heard_units[u]) begin
						age = clock_ticks - stamp[u];
						if (age > timeout_limit) begin
							unit_status[u] = 1'b1;
							r.ok = 1'b0;
							found = 1;
						end
					end
				end
			end
			default: ;
		endcase
		r.mask   = unit_status;
		r.linked = (unit_status == '0);
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic compare_status(hb_result_t got);
		hb_result_t want;
		if (expected_status.size() == 0) begin
			report("unexpected result", got.mask, '0);
		end else begin
			want = expected_status.pop_front();
			if (got.ok !== want.ok) report("check_ok", got.ok, want.ok);
			if (got.linked !== want.linked) report("all_linked", got.linked, want.linked);
			if (got.mask !== want.mask) report("status_mask", got.mask, want.mask);
			if (got.ierr !== want.ierr) report("index_error", got.ierr, want.ierr);
		end
	endtask

	function automatic hb_item_t make_item(logic [1:0] req, logic [4:0] unit);
		hb_item_t it;
		it.req  = req;
		it.unit = unit;
		return it;
	endfunction

	function automatic hb_item_t rand_item();
		int r;
		logic [4:0] unit;
		r = $urandom_range(0, 99);
		unit = 5'($urandom_range(0, 31));
		if (r < 45) begin
			return make_item(REQ_TICK, unit);
		end else if (r < 75) begin
			if ($urandom_range(0, 9) == 0) begin
				unit = 5'($urandom_range(NUM_UNITS, 31));
			end else begin
				unit = 5'($urandom_range(0, NUM_UNITS - 1));
			end
			return make_item(REQ_HEARTBEAT, unit);
		end else if (r < 95) begin
			return make_item(REQ_CHECK, unit);
		end
		return make_item(REQ_RESERVED, unit);
	endfunction

	task automatic add_random(int n);
		repeat (n) pending_items.push_back(rand_item());
	endtask

	// sender holds off until every expected result is back and the block is quiet
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_status.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		timeout_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// monitor: input and output transfers, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_status.push_back(predict_status(make_item(req_type, unit_index)));
				in_taken = 1;
			end
			if (out_valid && !out_stall) begin
				compare_status({check_ok, all_linked, status_mask, index_error});
				out_taken = 1;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin : drive_inputs
		hb_item_t nxt;
		if (arst_n && (in_taken || !in_valid)) begin
			in_taken = 0;
			if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else begin
				nxt = pending_items.pop_front();
				req_type   <= nxt.req;
				unit_index <= nxt.unit;
				in_valid   <= 1'b1;
				if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, 9);
			end
		end
	end

	always @(negedge clk) begin
		if (out_taken) begin
			out_taken = 0;
			if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
			stall_left = out_burst ? 0 : $urandom_range(0, 9);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		logic [31:0] phase_timeout [6];
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		pending_items.push_back(make_item(REQ_CHECK, 5'd0));
		pending_items.push_back(make_item(REQ_TICK, 5'd31));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(NONE_UNIT)));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(SYSTEM_UNIT)));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(NUM_UNITS)));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'd31));
		pending_items.push_back(make_item(REQ_RESERVED, 5'd31));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(NUM_UNITS - 1)));
		for (int u = 2; u < NUM_UNITS - 1; u++) begin
			pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(u)));
		end
		pending_items.push_back(make_item(REQ_TICK, 5'd0));
		pending_items.push_back(make_item(REQ_CHECK, 5'd31));
		drain();

		// zero timeout: any nonzero age is lost
		write_timeout(32'd0);
		pending_items.push_back(make_item(REQ_CHECK, 5'd0));
		pending_items.push_back(make_item(REQ_CHECK, 5'd0));
		pending_items.push_back(make_item(REQ_HEARTBEAT, 5'(SYSTEM_UNIT)));
		pending_items.push_back(make_item(REQ_CHECK, 5'd0));
		drain();

		write_timeout(32'hFFFF_FFFF);
		pending_items.push_back(make_item(REQ_TICK, 5'd0));
		pending_items.push_back(make_item(REQ_CHECK, 5'd0));
		drain();

		phase_timeout[0] = 32'd1;
		phase_timeout[1] = 32'($urandom_range(2, 15));
		phase_timeout[2] = 32'($urandom_range(16, 60));
		phase_timeout[3] = TIMEOUT_RST;
		phase_timeout[4] = 32'hFFFF_FFFF;
		phase_timeout[5] = 32'($urandom_range(5, 30));
		foreach (phase_timeout[p]) begin
			write_timeout(phase_timeout[p]);
			add_random(PHASE_ITEMS);
			drain();
		end

		if (expected_status.size() != 0) begin
			report("results never delivered", expected_status.size(), '0);
		end
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
